// ===== design/apm_pkg.sv =====
// ----------------------------------------------------------------------------
// apm_pkg
// Shared widths, register map and store control bundle for the amplitude and
// phase modulator.
// ----------------------------------------------------------------------------
package apm_pkg;

	localparam int SAMPLE_W = 16;
	localparam int SPAN_W   = 11;
	localparam int VOL_W    = 10;
	localparam int MODE_W   = 2;

	// register indices (byte address / 4)
	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_VOLUME = 2'd1;
	localparam logic [1:0] REG_MONO   = 2'd2;
	localparam logic [1:0] REG_SPAN   = 2'd3;

	// mode codes; any other phase code behaves as absolute-value
	localparam logic [MODE_W-1:0] MODE_AMP     = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BIPOLAR = 2'd1;

	typedef struct packed {
		logic wr;    // write the carriers at the write pointer; mono governs the right store
		logic adv;   // step the write pointer
		logic ch;    // channel whose read data is returned
		logic mono;  // right store keeps its contents once filled
	} store_ctl_t;

endpackage

// ===== design/amplitude_phase_modulator.sv =====
// ----------------------------------------------------------------------------
// amplitude_phase_modulator
// Stereo amplitude / phase modulator: ring product, interpolated read from a
// modulated delay line or the bare carrier, then volume gain and 16-bit saturation.
// ----------------------------------------------------------------------------
// channel   direction  handshake                fields
// s_axis    in         s_axis_tvalid/tready     carriers, modulators; tuser present
// m_axis    out        m_axis_tvalid/tready     out_left, out_right
// apb       in         psel/penable/pready      mode, volume, mono, delay_span
//
// One 18x18 multiplier is shared by every product under a sequencer. The frame
// path depends on mode: without modulator, in amplitude mode or in phase mode,
// each with a shorter path in mono; a delay that reaches the store depth has
// STORE_DEPTH taken off it per channel until it fits. The output register lets
// a new frame enter while a result waits. No clearing pass: a fill flag makes
// unwritten store entries read as zero.
// ----------------------------------------------------------------------------
module amplitude_phase_modulator import apm_pkg::*; #(
	parameter int STORE_DEPTH = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // carrier_left, carrier_right, mod_left, mod_right
	input  logic        s_axis_tuser,  // modulator_present
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // out_left, out_right
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int PW = $clog2(STORE_DEPTH);
	localparam int IW = ((PW > SPAN_W) ? PW : SPAN_W) + 1;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_WR   = 4'd1;
	localparam logic [3:0] S_CH   = 4'd2;
	localparam logic [3:0] S_AMP  = 4'd3;
	localparam logic [3:0] S_DF   = 4'd4;
	localparam logic [3:0] S_MODR = 4'd5;
	localparam logic [3:0] S_RDA  = 4'd6;
	localparam logic [3:0] S_RDB  = 4'd7;
	localparam logic [3:0] S_DIF  = 4'd8;
	localparam logic [3:0] S_ACC  = 4'd9;
	localparam logic [3:0] S_VMUL = 4'd10;
	localparam logic [3:0] S_VOL  = 4'd11;
	localparam logic [3:0] S_DONE = 4'd12;

	// configuration
	logic [MODE_W-1:0] mode_q;
	logic [VOL_W-1:0]  volume_q;
	logic              mono_q;
	logic [SPAN_W-1:0] span_q;

	logic [3:0]                 state_q;
	logic                       ch_q;
	logic                       present_q;
	logic                       phase_q;
	logic signed [SAMPLE_W-1:0] c_l_q, c_r_q, m_l_q, m_r_q;
	logic signed [SAMPLE_W-1:0] res_l_q, res_r_q;
	logic signed [SAMPLE_W-1:0] a_q;
	logic signed [16:0]         o_q;
	logic [SPAN_W-1:0]          r_q;
	logic [14:0]                f_q;
	logic [PW-1:0]              idx_q;
	logic signed [35:0]         prod_q;
	logic                       out_vld_q;
	logic [31:0]                out_data_q;

	logic signed [17:0]         mul_a, mul_b;
	logic signed [SAMPLE_W-1:0] c_sel, m_sel;
	logic [SPAN_W-1:0]          span1;
	logic signed [16:0]         m_ext, m_abs;
	logic signed [16:0]         diff;
	logic signed [35:0]         acc, acc_adj, amp_adj, vol_adj;
	logic signed [27:0]         vol_q28;
	logic signed [SAMPLE_W-1:0] vol_sat;
	logic [IW-1:0]              idx_diff, idx_wrap;
	logic                       bipolar;
	logic                       cfg_wr;
	logic                       out_load;
	store_ctl_t                 st_ctl;
	logic [PW-1:0]              wp;
	logic signed [SAMPLE_W-1:0] rd_data;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_AMP;
			volume_q <= VOL_W'(256);
			mono_q   <= 1'b0;
			span_q   <= SPAN_W'(1764);
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_MODE:   mode_q   <= pwdata[MODE_W-1:0];
				REG_VOLUME: volume_q <= pwdata[VOL_W-1:0];
				REG_MONO:   mono_q   <= pwdata[0];
				REG_SPAN:   span_q   <= pwdata[SPAN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_MODE:   prdata = 32'(mode_q);
			REG_VOLUME: prdata = 32'(volume_q);
			REG_MONO:   prdata = 32'(mono_q);
			REG_SPAN:   prdata = 32'(span_q);
			default:    prdata = '0;
		endcase
	end

	// per-channel operand selection
	assign c_sel   = ch_q ? c_r_q : c_l_q;
	assign m_sel   = ch_q ? m_r_q : m_l_q;
	assign bipolar = (mode_q == MODE_BIPOLAR);
	assign span1   = (span_q == '0) ? '0 : span_q - 1'b1;
	assign m_ext   = {m_sel[SAMPLE_W-1], m_sel};
	assign m_abs   = m_sel[SAMPLE_W-1] ? -m_ext : m_ext;
	assign diff    = {rd_data[SAMPLE_W-1], rd_data} - {a_q[SAMPLE_W-1], a_q};

	// shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_CH: begin
				if (!present_q) begin
					mul_a = 18'(c_sel);
					mul_b = {8'd0, volume_q};
				end else if (mode_q == MODE_AMP) begin
					mul_a = 18'(c_sel);
					mul_b = 18'(m_sel);
				end else begin
					// bipolar offset by 32768 is a flip of the sign bit
					mul_a = bipolar ? {2'b00, ~m_sel[SAMPLE_W-1], m_sel[SAMPLE_W-2:0]}
					                : {1'b0, m_abs};
					mul_b = {7'd0, span1};
				end
			end
			S_VMUL: begin
				mul_a = 18'(o_q);
				mul_b = {8'd0, volume_q};
			end
			S_DIF: begin
				mul_a = 18'(diff);
				mul_b = {3'd0, f_q};
			end
			default: ;
		endcase
	end

	// truncating divides: bias negatives before the arithmetic shift
	assign amp_adj = prod_q[35] ? prod_q + 36'sd32767 : prod_q;
	assign acc     = $signed({{5{a_q[SAMPLE_W-1]}}, a_q, 15'd0}) + prod_q;
	assign acc_adj = acc[35] ? acc + 36'sd32767 : acc;
	assign vol_adj = prod_q[35] ? prod_q + 36'sd255 : prod_q;
	assign vol_q28 = vol_adj[35:8];

	always_comb begin
		if (vol_q28 > 28'sd32767) begin
			vol_sat = 16'sh7FFF;
		end else if (vol_q28 < -28'sd32768) begin
			vol_sat = 16'sh8000;
		end else begin
			vol_sat = vol_q28[SAMPLE_W-1:0];
		end
	end

	// read index: pointer minus reduced delay, wrapped into the store
	assign idx_diff = IW'(wp) - IW'(r_q);
	assign idx_wrap = idx_diff[IW-1] ? idx_diff + IW'(STORE_DEPTH) : idx_diff;

	assign out_load = (state_q == S_DONE) && (!out_vld_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ch_q      <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						ch_q    <= 1'b0;
						state_q <= (s_axis_tuser && mode_q != MODE_AMP) ? S_WR : S_CH;
					end
				end
				S_WR:   state_q <= S_CH;
				S_CH: begin
					if (!present_q) begin
						state_q <= S_VOL;
					end else if (mode_q == MODE_AMP) begin
						state_q <= S_AMP;
					end else begin
						state_q <= S_DF;
					end
				end
				S_AMP:  state_q <= S_VMUL;
				S_DF:   state_q <= S_MODR;
				S_MODR: begin
					if (32'(r_q) < 32'(STORE_DEPTH)) begin
						state_q <= S_RDA;
					end
				end
				S_RDA:  state_q <= S_RDB;
				S_RDB:  state_q <= S_DIF;
				S_DIF:  state_q <= S_ACC;
				S_ACC:  state_q <= S_VMUL;
				S_VMUL: state_q <= S_VOL;
				S_VOL: begin
					if (!ch_q && !mono_q) begin
						ch_q    <= 1'b1;
						state_q <= S_CH;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) begin
					c_l_q     <= s_axis_tdata[15:0];
					c_r_q     <= s_axis_tdata[31:16];
					m_l_q     <= s_axis_tdata[47:32];
					m_r_q     <= s_axis_tdata[63:48];
					present_q <= s_axis_tuser;
					phase_q   <= s_axis_tuser && (mode_q != MODE_AMP);
				end
			end
			S_AMP:  o_q <= amp_adj[31:15];
			S_DF: begin
				if (bipolar) begin
					r_q <= prod_q[26:16];
					f_q <= prod_q[15:1];
				end else begin
					r_q <= prod_q[25:15];
					f_q <= prod_q[14:0];
				end
			end
			S_MODR: begin
				if (32'(r_q) >= 32'(STORE_DEPTH)) begin
					r_q <= r_q - SPAN_W'(STORE_DEPTH);
				end else begin
					idx_q <= idx_wrap[PW-1:0];
				end
			end
			S_RDA: begin
				// second tap sits one entry further back
				idx_q <= (idx_q == '0) ? PW'(STORE_DEPTH - 1) : idx_q - 1'b1;
			end
			S_RDB:  a_q <= rd_data;
			S_ACC:  o_q <= acc_adj[31:15];
			S_VOL: begin
				if (ch_q) begin
					res_r_q <= vol_sat;
				end else begin
					res_l_q <= vol_sat;
					if (mono_q) begin
						res_r_q <= '0;
					end
				end
			end
			S_DONE: begin
				if (out_load) begin
					out_data_q <= {res_r_q, res_l_q};
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		st_ctl.wr   = (state_q == S_WR);
		st_ctl.adv  = out_load && phase_q;
		st_ctl.ch   = ch_q;
		st_ctl.mono = mono_q;
	end

	apm_store #(
		.STORE_DEPTH(STORE_DEPTH),
		.PW         (PW)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (st_ctl),
		.wr_left (c_l_q),
		.wr_right(c_r_q),
		.rd_idx  (idx_q),
		.wp      (wp),
		.rd_data (rd_data)
	);

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

endmodule

// ===== design/apm_store.sv =====
// ----------------------------------------------------------------------------
// apm_store
// Left and right circular delay stores with write pointer and fill tracking.
// Entries not yet written since reset read back as zero.
// ----------------------------------------------------------------------------
module apm_store import apm_pkg::*; #(
	parameter int STORE_DEPTH = 2048,
	parameter int PW          = $clog2(STORE_DEPTH)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  store_ctl_t                 ctl,
	input  logic signed [SAMPLE_W-1:0] wr_left,
	input  logic signed [SAMPLE_W-1:0] wr_right,
	input  logic [PW-1:0]              rd_idx,
	output logic [PW-1:0]              wp,
	output logic signed [SAMPLE_W-1:0] rd_data
);

	logic signed [SAMPLE_W-1:0] mem_l [STORE_DEPTH];
	logic signed [SAMPLE_W-1:0] mem_r [STORE_DEPTH];
	logic signed [SAMPLE_W-1:0] rd_l_q;
	logic signed [SAMPLE_W-1:0] rd_r_q;
	logic                       vld_q;
	logic                       ch_q;
	logic [PW-1:0]              wp_q;
	logic                       full_q;
	logic                       wr_r;
	logic signed [SAMPLE_W-1:0] wr_r_data;

	// mono on the first lap writes zero so the fill tracking stays exact
	assign wr_r      = ctl.wr && (!ctl.mono || !full_q);
	assign wr_r_data = ctl.mono ? '0 : wr_right;

	always_ff @(posedge clk) begin
		if (ctl.wr) begin
			mem_l[wp_q] <= wr_left;
		end
		rd_l_q <= mem_l[rd_idx];
	end

	always_ff @(posedge clk) begin
		if (wr_r) begin
			mem_r[wp_q] <= wr_r_data;
		end
		rd_r_q <= mem_r[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			full_q <= 1'b0;
			vld_q  <= 1'b0;
			ch_q   <= 1'b0;
		end else begin
			vld_q <= full_q || (rd_idx <= wp_q);
			ch_q  <= ctl.ch;
			if (ctl.adv) begin
				if (wp_q == PW'(STORE_DEPTH - 1)) begin
					wp_q   <= '0;
					full_q <= 1'b1;
				end else begin
					wp_q <= wp_q + 1'b1;
				end
			end
		end
	end

	assign wp      = wp_q;
	assign rd_data = !vld_q ? '0 : (ch_q ? rd_r_q : rd_l_q);

endmodule
